// ----- rtl/core/tdpt_pkg.sv -----
package tdpt_pkg;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_CHECK,
		ST_DIVIDE,
		ST_TEST,
		ST_FINISH
	} tdpt_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_start;
		logic div_step;
		logic advance;
		logic set_verdict;
		logic verdict;
		logic emit;
	} tdpt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic trivial;
		logic trivial_prime;
		logic bound_exceeded;
		logic div_last;
		logic rem_zero;
	} tdpt_status_t;

endpackage

// ----- rtl/core/tdpt_datapath.sv -----
module tdpt_datapath #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic [NUM_WIDTH-1:0]  candidate,
	input  tdpt_pkg::tdpt_cmd_t   cmd,
	output tdpt_pkg::tdpt_status_t status,
	output logic                  is_prime
);
	import tdpt_pkg::*;

	localparam int W  = NUM_WIDTH;
	localparam int CW = $clog2(NUM_WIDTH);

	logic [W-1:0]  n_q;
	logic [W-1:0]  d_q;
	logic [W+1:0]  sq_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  shift_q;
	logic [CW-1:0] cnt_q;
	logic          verdict_q;
	logic          is_prime_q;

	logic [W:0]    trial;
	logic [W:0]    trial_diff;
	logic          trial_fits;

	// One restoring division step: bring down the next candidate bit and
	// subtract the divisor when it fits.
	assign trial      = {rem_q, shift_q[W-1]};
	assign trial_fits = trial >= {1'b0, d_q};
	assign trial_diff = trial - {1'b0, d_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q  <= candidate;
			d_q  <= W'(3);
			sq_q <= (W+2)'(9);
		end else if (cmd.advance) begin
			// (d + 2)^2 = d^2 + 4d + 4
			sq_q <= sq_q + {d_q, 2'b00} + (W+2)'(4);
			d_q  <= d_q + W'(2);
		end

		if (cmd.div_start) begin
			rem_q   <= '0;
			shift_q <= n_q;
			cnt_q   <= CW'(W - 1);
		end else if (cmd.div_step) begin
			rem_q   <= trial_fits ? trial_diff[W-1:0] : trial[W-1:0];
			shift_q <= {shift_q[W-2:0], 1'b0};
			cnt_q   <= cnt_q - CW'(1);
		end

		if (cmd.set_verdict) begin
			verdict_q <= cmd.verdict;
		end

		if (cmd.emit) begin
			is_prime_q <= verdict_q;
		end
	end

	always_comb begin
		status.trivial        = (n_q < W'(2)) || !n_q[0];
		status.trivial_prime  = n_q == W'(2);
		status.bound_exceeded = sq_q > {2'b00, n_q};
		status.div_last       = cnt_q == '0;
		status.rem_zero       = rem_q == '0;
	end

	assign is_prime = is_prime_q;

endmodule

// ----- rtl/core/tdpt_controller.sv -----
module tdpt_controller (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cand_valid,
	output logic                   cand_stall,
	output logic                   res_valid,
	input  logic                   res_stall,
	input  tdpt_pkg::tdpt_status_t status,
	output tdpt_pkg::tdpt_cmd_t    cmd
);
	import tdpt_pkg::*;

	tdpt_state_t state_q;
	tdpt_state_t state_next;
	logic        res_valid_q;
	logic        out_free;

	// The result register can be loaded when empty or when its request
	// leaves at this edge.
	assign out_free = !res_valid_q || !res_stall;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cand_valid) state_next = ST_CLASSIFY;
			end
			ST_CLASSIFY: begin
				state_next = status.trivial ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				state_next = status.bound_exceeded ? ST_FINISH : ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (status.div_last) state_next = ST_TEST;
			end
			ST_TEST: begin
				state_next = status.rem_zero ? ST_FINISH : ST_CHECK;
			end
			ST_FINISH: begin
				if (out_free) state_next = ST_IDLE;
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = cand_valid;
			end
			ST_CLASSIFY: begin
				cmd.set_verdict = status.trivial;
				cmd.verdict     = status.trivial_prime;
			end
			ST_CHECK: begin
				cmd.set_verdict = status.bound_exceeded;
				cmd.verdict     = 1'b1;
				cmd.div_start   = !status.bound_exceeded;
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
			end
			ST_TEST: begin
				cmd.set_verdict = status.rem_zero;
				cmd.verdict     = 1'b0;
				cmd.advance     = !status.rem_zero;
			end
			ST_FINISH: begin
				cmd.emit = out_free;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.emit) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign cand_stall = state_q != ST_IDLE;
	assign res_valid  = res_valid_q;

endmodule

// ----- rtl/core/trial_division_prime_test.sv -----
// Channel    Signals                                  Direction
// ---------  ---------------------------------------  ---------
// request    cand_valid, cand_stall, candidate        in
// result     res_valid, res_stall, is_prime           out
//
// One candidate is worked on at a time. Zero, one and even candidates are
// settled by the classify step alone. An odd candidate n is divided by each
// odd divisor tried, up to roughly sqrt(n) / 2 of them, in the bit-serial
// remainder unit, one quotient bit per cycle.
// Reset clears the controller and the result valid flag only.
// A new request is taken while a finished result is still held by res_stall;
// the next verdict then waits in the controller until the result leaves.
module trial_division_prime_test #(
	parameter int NUM_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cand_valid,
	output logic                 cand_stall,
	input  logic [NUM_WIDTH-1:0] candidate,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic                 is_prime
);
	import tdpt_pkg::*;

	tdpt_cmd_t    cmd;
	tdpt_status_t status;

	// The controller sequences classification, the bound check against the
	// running divisor square, the remainder steps and the result hand-off.
	tdpt_controller u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cand_valid (cand_valid),
		.cand_stall (cand_stall),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.status     (status),
		.cmd        (cmd)
	);

	// The datapath holds the candidate, the odd divisor and its square, kept
	// up to date by adding 4d + 4, and the restoring remainder unit.
	tdpt_datapath #(
		.NUM_WIDTH (NUM_WIDTH)
	) u_dp (
		.clk       (clk),
		.candidate (candidate),
		.cmd       (cmd),
		.status    (status),
		.is_prime  (is_prime)
	);

endmodule
